// ----- hdl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot reservation table package
// Holds the sizes, codes and types that the table cells and the controller share.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int AGENT_W     = 8;
    localparam int STEP_W      = 16;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [FUNC_W-1:0] FN_CHECK    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FIND     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RESERVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NEXT     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RSV_NEXT = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_COPY     = 3'd6;
    localparam logic [FUNC_W-1:0] FN_COUNT    = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  slot_time;
        logic [AGENT_W-1:0] agent;
    } entry_t;

    typedef struct packed {
        entry_t main_e;
        entry_t pre_e;
    } cell_data_t;

    // Controls common to every cell.
    typedef struct packed {
        logic rot_main;
        logic rot_pre;
        logic copy;
    } cell_ctrl_t;

    // Controls that differ from cell to cell.
    typedef struct packed {
        logic load_main;
        logic load_pre;
        logic shift_main;
        logic shift_pre;
    } cell_sel_t;

endpackage

// ----- hdl/srt_cell.sv -----
// ----------------------------------------------------------------------------
// Slot reservation table cell
// Holds one main and one preliminary entry and passes them to its left neighbor.
// ----------------------------------------------------------------------------
module srt_cell (
    input  logic                aclk,
    input  srt_pkg::cell_ctrl_t ctrl,
    input  srt_pkg::cell_sel_t  sel,
    input  srt_pkg::entry_t     wr_entry,
    input  srt_pkg::cell_data_t nb_in,
    output srt_pkg::cell_data_t data_out
);

    srt_pkg::cell_data_t data_reg;
    srt_pkg::cell_data_t data_next;

    always_comb begin
        data_next = data_reg;
        if (sel.load_main) begin
            data_next.main_e = wr_entry;
        end else if (ctrl.rot_main || sel.shift_main) begin
            data_next.main_e = nb_in.main_e;
        end
        if (ctrl.copy) begin
            data_next.pre_e = data_reg.main_e;
        end else if (sel.load_pre) begin
            data_next.pre_e = wr_entry;
        end else if (ctrl.rot_pre || sel.shift_pre) begin
            data_next.pre_e = nb_in.pre_e;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ----- hdl/slot_reservation_table_unit.sv -----
// ----------------------------------------------------------------------------
// Slot reservation table unit
// Main and preliminary reservation tables kept in a ring of cells, searched by
// rotating the ring past a compare stage at its head.
// ----------------------------------------------------------------------------
//  Channel  | Ports      | Beat
//  input    | s_axis_*   | tuser: func, use_prelim; tdata: agent_id, query_time
//  result   | m_axis_*   | tuser: status; tdata: result_time, entry_count
//  config   | APB        | slot_step at byte address 0
//
// Each pass rotates the selected table once around the ring. Check, find,
// reserve and a main remove take one pass, an evaluation step and a done step.
// A next-free search repeats the pass and evaluation for each candidate (up to
// TABLE_DEPTH + 1); a preliminary remove repeats them after each removed entry
// until a pass finds none. Copy and count skip the pass. Reset clears the fill
// counts; a stalled result holds the unit.
// ----------------------------------------------------------------------------
module slot_reservation_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // agent_id[7:0], query_time[39:8]
    input  logic [3:0]  s_axis_tuser,   // func[2:0], use_prelim[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_time[31:0], entry_count[38:32]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = srt_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_EVAL, S_DONE} state_t;

    state_t                          state_reg;
    logic [srt_pkg::STEP_W-1:0]      step_reg;
    logic [srt_pkg::FUNC_W-1:0]      func_reg;
    logic                            pre_reg;
    logic [srt_pkg::AGENT_W-1:0]     agent_reg;
    logic [srt_pkg::TIME_W-1:0]      query_reg;
    logic [srt_pkg::TIME_W-1:0]      cand_reg;
    logic [srt_pkg::CNT_W-1:0]       try_reg;
    logic [srt_pkg::IDX_W-1:0]       k_reg;
    logic                            hit_reg;
    logic [srt_pkg::IDX_W-1:0]       hit_idx_reg;
    logic [srt_pkg::TIME_W-1:0]      hit_time_reg;
    logic                            removed_reg;
    logic [srt_pkg::CNT_W-1:0]       main_fill_reg;
    logic [srt_pkg::CNT_W-1:0]       pre_fill_reg;
    logic [srt_pkg::STATUS_W-1:0]    res_status_reg;
    logic [srt_pkg::TIME_W-1:0]      res_time_reg;
    logic                            m_valid_reg;
    logic [39:0]                     m_data_reg;
    logic [1:0]                      m_user_reg;

    srt_pkg::cell_data_t             cells [N];
    srt_pkg::cell_ctrl_t             ctrl;
    srt_pkg::cell_sel_t              sel [N];
    srt_pkg::entry_t                 wr_entry;

    logic                            tsel;
    logic [srt_pkg::CNT_W-1:0]       fill_sel;
    srt_pkg::entry_t                 head;
    logic                            head_valid;
    logic [srt_pkg::TIME_W-1:0]      cmp_time;
    logic                            do_load;
    logic                            do_shift;
    logic                            s_accept;
    logic                            cfg_wr;
    logic [srt_pkg::CNT_W-1:0]       out_count;

    assign tsel       = pre_reg && (func_reg != srt_pkg::FN_RSV_NEXT);
    assign fill_sel   = tsel ? pre_fill_reg : main_fill_reg;
    assign head       = tsel ? cells[0].pre_e : cells[0].main_e;
    assign head_valid = {1'b0, k_reg} < fill_sel;
    assign cmp_time   = (func_reg == srt_pkg::FN_CHECK || func_reg == srt_pkg::FN_RESERVE)
                        ? query_reg : cand_reg;
    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == 1'b0) ? {16'd0, step_reg} : 32'd0;

    // Load and compact decisions are made at the end of a pass.
    always_comb begin
        do_load  = 1'b0;
        do_shift = 1'b0;
        if (state_reg == S_EVAL && fill_sel != srt_pkg::CNT_W'(N)) begin
            if (func_reg == srt_pkg::FN_RESERVE && !hit_reg) begin
                do_load = 1'b1;
            end
            if (func_reg == srt_pkg::FN_RSV_NEXT && !hit_reg) begin
                do_load = 1'b1;
            end
        end
        if (state_reg == S_EVAL && func_reg == srt_pkg::FN_REMOVE && hit_reg) begin
            do_shift = 1'b1;
        end
    end

    always_comb begin
        ctrl.rot_main = (state_reg == S_PASS) && !tsel;
        ctrl.rot_pre  = (state_reg == S_PASS) && tsel;
        ctrl.copy     = (state_reg == S_EVAL) && (func_reg == srt_pkg::FN_COPY);
        wr_entry.slot_time = (func_reg == srt_pkg::FN_RESERVE) ? query_reg : cand_reg;
        wr_entry.agent     = agent_reg;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        always_comb begin
            sel[i].load_main  = do_load && !tsel && (fill_sel == srt_pkg::CNT_W'(i));
            sel[i].load_pre   = do_load && tsel && (fill_sel == srt_pkg::CNT_W'(i));
            sel[i].shift_main = do_shift && !tsel && (srt_pkg::CNT_W'(i) >= {1'b0, hit_idx_reg});
            sel[i].shift_pre  = do_shift && tsel && (srt_pkg::CNT_W'(i) >= {1'b0, hit_idx_reg});
        end
        srt_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .sel      (sel[i]),
            .wr_entry (wr_entry),
            .nb_in    (cells[(i + 1) % N]),
            .data_out (cells[i])
        );
    end

    assign out_count = (func_reg == srt_pkg::FN_COPY) ? pre_fill_reg : fill_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= srt_pkg::STEP_W'(1);
            main_fill_reg <= '0;
            pre_fill_reg  <= '0;
            m_valid_reg   <= 1'b0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            removed_reg   <= 1'b0;
            try_reg       <= '0;
        end else begin
            if (cfg_wr && paddr[2] == 1'b0) begin
                step_reg <= pwdata[srt_pkg::STEP_W-1:0];
            end
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        func_reg    <= s_axis_tuser[2:0];
                        pre_reg     <= s_axis_tuser[3];
                        agent_reg   <= s_axis_tdata[7:0];
                        query_reg   <= s_axis_tdata[39:8];
                        cand_reg    <= s_axis_tdata[39:8];
                        try_reg     <= '0;
                        k_reg       <= '0;
                        hit_reg     <= 1'b0;
                        removed_reg <= 1'b0;
                        hit_time_reg <= '0;
                        if (s_axis_tuser[2:0] == srt_pkg::FN_COPY ||
                            s_axis_tuser[2:0] == srt_pkg::FN_COUNT) begin
                            state_reg <= S_EVAL;
                        end else begin
                            state_reg <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    if (head_valid && !hit_reg) begin
                        if (func_reg == srt_pkg::FN_FIND) begin
                            if (head.agent == agent_reg && head.slot_time >= query_reg) begin
                                hit_reg      <= 1'b1;
                                hit_time_reg <= head.slot_time;
                            end
                        end else if (func_reg == srt_pkg::FN_REMOVE) begin
                            if (head.agent == agent_reg) begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= k_reg;
                            end
                        end else if (head.slot_time == cmp_time) begin
                            hit_reg <= 1'b1;
                        end
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == srt_pkg::IDX_W'(N - 1)) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    state_reg      <= S_DONE;
                    res_status_reg <= srt_pkg::ST_OK;
                    res_time_reg   <= '0;
                    unique case (func_reg)
                        srt_pkg::FN_CHECK: begin
                            res_status_reg <= hit_reg ? srt_pkg::ST_TAKEN : srt_pkg::ST_OK;
                            res_time_reg   <= hit_reg ? '0 : query_reg;
                        end
                        srt_pkg::FN_FIND: begin
                            res_status_reg <= hit_reg ? srt_pkg::ST_OK : srt_pkg::ST_TAKEN;
                            res_time_reg   <= hit_time_reg;
                        end
                        srt_pkg::FN_RESERVE, srt_pkg::FN_NEXT, srt_pkg::FN_RSV_NEXT: begin
                            if (hit_reg) begin
                                res_status_reg <= srt_pkg::ST_TAKEN;
                                if (func_reg != srt_pkg::FN_RESERVE &&
                                    try_reg != srt_pkg::CNT_W'(N)) begin
                                    cand_reg  <= cand_reg + srt_pkg::TIME_W'(step_reg);
                                    try_reg   <= try_reg + 1'b1;
                                    hit_reg   <= 1'b0;
                                    k_reg     <= '0;
                                    state_reg <= S_PASS;
                                end
                            end else if (func_reg == srt_pkg::FN_NEXT) begin
                                res_time_reg <= cand_reg;
                            end else if (fill_sel == srt_pkg::CNT_W'(N)) begin
                                res_status_reg <= srt_pkg::ST_FULL;
                            end else begin
                                res_time_reg <= wr_entry.slot_time;
                                if (tsel) begin
                                    pre_fill_reg <= pre_fill_reg + 1'b1;
                                end else begin
                                    main_fill_reg <= main_fill_reg + 1'b1;
                                end
                            end
                        end
                        srt_pkg::FN_REMOVE: begin
                            if (hit_reg) begin
                                if (tsel) begin
                                    pre_fill_reg <= pre_fill_reg - 1'b1;
                                    removed_reg  <= 1'b1;
                                    hit_reg      <= 1'b0;
                                    k_reg        <= '0;
                                    state_reg    <= S_PASS;
                                end else begin
                                    main_fill_reg <= main_fill_reg - 1'b1;
                                end
                            end else begin
                                res_status_reg <= removed_reg ? srt_pkg::ST_OK
                                                              : srt_pkg::ST_TAKEN;
                            end
                        end
                        srt_pkg::FN_COPY: begin
                            pre_fill_reg <= main_fill_reg;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, out_count, res_time_reg};
                        m_user_reg  <= res_status_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_main_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        main_fill_reg <= srt_pkg::CNT_W'(N))
        else $error("main fill exceeds table depth");

    a_pre_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pre_fill_reg <= srt_pkg::CNT_W'(N))
        else $error("preliminary fill exceeds table depth");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_PASS || state_reg == S_EVAL))
        else $error("accepted beat did not start work");

    a_fill_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(main_fill_reg) |-> $past(state_reg) == S_EVAL)
        else $error("main fill changed outside evaluation");

endmodule

// ----- tb/sv/slot_reservation_table_checker.sv -----
// ----------------------------------------------------------------------------
// Slot reservation table checker
// Watches the request, reply and register channels of the unit. It keeps its
// own copy of both tables and the slot period, works out the reply to every
// accepted request, and compares each reply beat field by field in order.
// ----------------------------------------------------------------------------
module slot_reservation_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // agent_id[7:0], query_time[39:8]
    input  logic [3:0]  s_axis_tuser,   // func[2:0], use_prelim[3]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // result_time[31:0], entry_count[38:32]
    input  logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          failures,
    output int          pending
);

    localparam logic [2:0] ADDR_SLOT_STEP = 3'd0;

    typedef struct packed {
        logic [srt_pkg::STATUS_W-1:0] status;
        logic [srt_pkg::TIME_W-1:0]   slot_time;
        logic [srt_pkg::CNT_W-1:0]    count;
    } reply_t;

    logic [srt_pkg::TIME_W-1:0]  main_time   [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::AGENT_W-1:0] main_agent  [srt_pkg::TABLE_DEPTH];
    int                          main_used;
    logic [srt_pkg::TIME_W-1:0]  pre_time    [srt_pkg::TABLE_DEPTH];
    logic [srt_pkg::AGENT_W-1:0] pre_agent   [srt_pkg::TABLE_DEPTH];
    int                          pre_used;
    logic [srt_pkg::STEP_W-1:0]  slot_period;
    reply_t                      expected_replies[$];

    function automatic bit is_taken(bit pre, logic [srt_pkg::TIME_W-1:0] t);
        int n;
        n = pre ? pre_used : main_used;
        for (int i = 0; i < n; i++) begin
            if ((pre ? pre_time[i] : main_time[i]) == t) return 1;
        end
        return 0;
    endfunction

    function automatic bit search_free(bit pre, logic [srt_pkg::TIME_W-1:0] start,
                                       output logic [srt_pkg::TIME_W-1:0] found);
        logic [srt_pkg::TIME_W-1:0] cand;
        cand  = start;
        found = '0;
        for (int i = 0; i <= srt_pkg::TABLE_DEPTH; i++) begin
            if (!is_taken(pre, cand)) begin
                found = cand;
                return 1;
            end
            cand = cand + srt_pkg::TIME_W'(slot_period);
        end
        return 0;
    endfunction

    task automatic book_slot(bit pre, logic [srt_pkg::AGENT_W-1:0] who,
                             logic [srt_pkg::TIME_W-1:0] t,
                             output logic [srt_pkg::STATUS_W-1:0] st);
        if (is_taken(pre, t)) begin
            st = srt_pkg::ST_TAKEN;
        end else if ((pre ? pre_used : main_used) >= srt_pkg::TABLE_DEPTH) begin
            st = srt_pkg::ST_FULL;
        end else begin
            st = srt_pkg::ST_OK;
            if (pre) begin
                pre_time[pre_used]  = t;
                pre_agent[pre_used] = who;
                pre_used++;
            end else begin
                main_time[main_used]  = t;
                main_agent[main_used] = who;
                main_used++;
            end
        end
    endtask

    task automatic drop_entry(bit pre, int idx);
        if (pre) begin
            for (int k = idx; k < pre_used - 1; k++) begin
                pre_time[k]  = pre_time[k+1];
                pre_agent[k] = pre_agent[k+1];
            end
            pre_used--;
        end else begin
            for (int k = idx; k < main_used - 1; k++) begin
                main_time[k]  = main_time[k+1];
                main_agent[k] = main_agent[k+1];
            end
            main_used--;
        end
    endtask

    task automatic apply_request(logic [srt_pkg::FUNC_W-1:0] fn, bit pre,
                                 logic [srt_pkg::AGENT_W-1:0] who,
                                 logic [srt_pkg::TIME_W-1:0] q, output reply_t r);
        logic [srt_pkg::TIME_W-1:0] t;
        int                         i;
        r.status    = srt_pkg::ST_OK;
        r.slot_time = '0;
        case (fn)
            srt_pkg::FN_CHECK: begin
                if (is_taken(pre, q)) r.status = srt_pkg::ST_TAKEN;
                else r.slot_time = q;
            end
            srt_pkg::FN_FIND: begin
                r.status = srt_pkg::ST_TAKEN;
                for (i = 0; i < (pre ? pre_used : main_used); i++) begin
                    if ((pre ? pre_agent[i] : main_agent[i]) == who &&
                        (pre ? pre_time[i] : main_time[i]) >= q) begin
                        r.status    = srt_pkg::ST_OK;
                        r.slot_time = pre ? pre_time[i] : main_time[i];
                        break;
                    end
                end
            end
            srt_pkg::FN_RESERVE: begin
                book_slot(pre, who, q, r.status);
                if (r.status == srt_pkg::ST_OK) r.slot_time = q;
            end
            srt_pkg::FN_NEXT: begin
                if (search_free(pre, q, t)) r.slot_time = t;
                else r.status = srt_pkg::ST_TAKEN;
            end
            srt_pkg::FN_RSV_NEXT: begin
                pre = 0;
                if (!search_free(0, q, t)) begin
                    r.status = srt_pkg::ST_TAKEN;
                end else begin
                    book_slot(0, who, t, r.status);
                    if (r.status == srt_pkg::ST_OK) r.slot_time = t;
                end
            end
            srt_pkg::FN_REMOVE: begin
                r.status = srt_pkg::ST_TAKEN;
                i = 0;
                while (i < (pre ? pre_used : main_used)) begin
                    if ((pre ? pre_agent[i] : main_agent[i]) == who) begin
                        drop_entry(pre, i);
                        r.status = srt_pkg::ST_OK;
                        if (!pre) break;
                    end else begin
                        i++;
                    end
                end
            end
            srt_pkg::FN_COPY: begin
                pre = 1;
                for (int k = 0; k < srt_pkg::TABLE_DEPTH; k++) begin
                    pre_time[k]  = main_time[k];
                    pre_agent[k] = main_agent[k];
                end
                pre_used = main_used;
            end
            default: ;
        endcase
        r.count = srt_pkg::CNT_W'(pre ? pre_used : main_used);
    endtask

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            main_used   = 0;
            pre_used    = 0;
            slot_period = 16'd1;
            failures    <= 0;
            pending     <= 0;
            expected_replies.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SLOT_STEP)
                slot_period = pwdata[srt_pkg::STEP_W-1:0];
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[7:0],
                              s_axis_tdata[39:8], want);
                expected_replies = {expected_replies, want};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tuser;
                got.slot_time = m_axis_tdata[31:0];
                got.count     = m_axis_tdata[38:32];
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply beat status=%0d time=%h count=%0d",
                             $time, got.status, got.slot_time, got.count);
                    failures <= failures + 1;
                end else begin
                    want = expected_replies.pop_front();
                    if (got != want || m_axis_tdata[39] !== 1'b0) begin
                        $display("%0t: reply mismatch expected status=%0d time=%h count=%0d",
                                 $time, want.status, want.slot_time, want.count);
                        $display("%0t:                  actual status=%0d time=%h count=%0d",
                                 $time, got.status, got.slot_time, got.count);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= expected_replies.size();
        end
    end

endmodule

// ----- tb/sv/slot_reservation_table_unit_test.sv -----
// ----------------------------------------------------------------------------
// Slot reservation table unit test
// Drives directed and random requests and slot period writes into the unit
// under random stalls on both sides outside a calm window, with one long reply
// hold-off; the checker beside the unit predicts and compares every reply.
// ----------------------------------------------------------------------------
module slot_reservation_table_unit_test;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int CALM_FROM   = 3000;
    localparam int CALM_TO     = 9000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          failures;
    int          pending;
    int          cycle = 0;
    int          hold_left = 0;
    bit          hold_done = 0;

    slot_reservation_table_unit DUT (.*);

    slot_reservation_table_checker checker_i (.*);

    always #10 aclk = ~aclk;

    function automatic bit calm();
        return cycle >= CALM_FROM && cycle < CALM_TO;
    endfunction

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!hold_done && cycle == 20000) begin
            hold_done     <= 1;
            hold_left     <= 600;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= calm() || $urandom_range(0, 99) >= 21;
        end
    end

    task automatic send(logic [srt_pkg::FUNC_W-1:0] fn, bit pre,
                        logic [srt_pkg::AGENT_W-1:0] who, logic [srt_pkg::TIME_W-1:0] t);
        while (!calm() && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= {pre, fn};
        s_axis_tdata  <= {t, who};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic set_period(logic [srt_pkg::STEP_W-1:0] step);
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= 3'd0;
        pwdata  <= {16'h0, step};
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic random_request(logic [srt_pkg::TIME_W-1:0] base);
        logic [srt_pkg::FUNC_W-1:0]  fn;
        logic [srt_pkg::AGENT_W-1:0] who;
        logic [srt_pkg::TIME_W-1:0]  t;
        int                          pick;
        pick = $urandom_range(0, 99);
        fn = pick < 20 ? srt_pkg::FN_RESERVE : pick < 40 ? srt_pkg::FN_RSV_NEXT :
             pick < 50 ? srt_pkg::FN_CHECK : pick < 60 ? srt_pkg::FN_FIND :
             pick < 70 ? srt_pkg::FN_NEXT : pick < 88 ? srt_pkg::FN_REMOVE :
             pick < 94 ? srt_pkg::FN_COPY : srt_pkg::FN_COUNT;
        who = srt_pkg::AGENT_W'($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        t = pick < 70 ? base + $urandom_range(0, 80) :
            pick < 85 ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 80);
        send(fn, 1'($urandom_range(0, 1)), who, t);
    endtask

    initial begin
        logic [srt_pkg::TIME_W-1:0] base;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_period(16'd1);

        send(srt_pkg::FN_COUNT,    1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_CHECK,    1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_FIND,     1'b1, 8'd9,   32'd0);
        send(srt_pkg::FN_REMOVE,   1'b0, 8'd9,   32'd0);
        send(srt_pkg::FN_REMOVE,   1'b1, 8'd9,   32'd0);
        send(srt_pkg::FN_RESERVE,  1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_RESERVE,  1'b0, 8'd255, 32'hFFFF_FFFF);
        send(srt_pkg::FN_RESERVE,  1'b0, 8'd7,   32'd0);
        send(srt_pkg::FN_CHECK,    1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_CHECK,    1'b0, 8'd0,   32'hFFFF_FFFF);
        send(srt_pkg::FN_FIND,     1'b0, 8'd255, 32'd0);
        send(srt_pkg::FN_FIND,     1'b0, 8'd0,   32'd1);
        send(srt_pkg::FN_NEXT,     1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_RSV_NEXT, 1'b1, 8'd3,   32'd0);
        send(srt_pkg::FN_NEXT,     1'b0, 8'd0,   32'hFFFF_FFFF);
        send(srt_pkg::FN_COPY,     1'b0, 8'd0,   32'd0);
        send(srt_pkg::FN_RESERVE,  1'b1, 8'd3,   32'd50);
        send(srt_pkg::FN_RESERVE,  1'b1, 8'd3,   32'd60);
        send(srt_pkg::FN_REMOVE,   1'b1, 8'd3,   32'd0);
        send(srt_pkg::FN_RESERVE,  1'b0, 8'd255, 32'd2);
        send(srt_pkg::FN_REMOVE,   1'b0, 8'd255, 32'd0);
        send(srt_pkg::FN_COUNT,    1'b1, 8'd0,   32'd0);
        send(srt_pkg::FN_COUNT,    1'b0, 8'd0,   32'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_period(16'hFFFF);
                1: set_period(16'd1);
                2: set_period(srt_pkg::STEP_W'($urandom_range(2, 65534)));
                default: set_period(16'd1);
            endcase
            base = phase == 1 ? 32'hFFFF_FFC0 : $urandom();
            for (int n = 0; n < 70; n++)
                send(srt_pkg::FN_RSV_NEXT, 1'b0,
                     srt_pkg::AGENT_W'($urandom_range(0, 255)), base);
            send(srt_pkg::FN_RESERVE, 1'b0, 8'd1, base - 1);
            send(srt_pkg::FN_NEXT, 1'b0, 8'd1, base);
            send(srt_pkg::FN_COPY, 1'b0, 8'd0, 32'd0);
            send(srt_pkg::FN_RESERVE, 1'b1, 8'd1, base - 1);
            for (int n = 0; n < 100; n++)
                random_request(base);
        end

        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
